// ===== rtl/a2pa_pkg.sv =====
// Shared types, widths and constants for the atan2 polynomial pipeline.
// No dependencies; imported by a2pa_div, a2pa_poly and atan2_poly_approx_top.
package a2pa_pkg;

    localparam int DEF_COORD_WIDTH     = 16;
    localparam int DEF_ANGLE_FRAC_BITS = 13;

    localparam int ANGLE_W    = 16;   // result word
    localparam int RATIO_FRAC = 15;   // fraction bits of ratio and square
    localparam int RATIO_W    = 16;   // 1.0 is held as 2^15
    localparam int ACC_W      = 18;   // Horner accumulator, 16 fraction bits
    localparam int PROD_W     = 35;   // accumulator times ratio or square
    localparam int COEF_COUNT = 6;

    typedef logic signed [ACC_W-1:0] t_acc;

    // odd polynomial for atan on the first octant, 16 fraction bits
    localparam t_acc COEF [COEF_COUNT] = '{
        -18'sd883, 18'sd3767, -18'sd7946, 18'sd12821, -18'sd21823, 18'sd65536
    };

    // pi with 60 fraction bits
    localparam logic [63:0] PI_Q60 = 64'h3243_F6A8_885A_308D;

    // side information that rides along with each item
    typedef struct packed {
        logic zero;    // x and y both zero
        logic swap;    // |y| > |x|
        logic x_neg;
        logic y_neg;
    } t_side;

    function automatic logic [63:0] pi_fixed(input int frac);
        pi_fixed = (PI_Q60 + (64'd1 << (59 - frac))) >> (60 - frac);
    endfunction

    function automatic logic [63:0] half_pi_fixed(input int frac);
        half_pi_fixed = (PI_Q60 + (64'd1 << (60 - frac))) >> (61 - frac);
    endfunction

endpackage

// ===== rtl/atan2_poly_approx_top.sv =====
// Top level of the atan2 pipeline: magnitudes, divider, polynomial, quadrant
// restore and output skid. Depends on a2pa_pkg, a2pa_div and a2pa_poly.

// Gives atan2(y, x) in radians with ANGLE_FRAC_BITS fraction bits (Q3.13 by
// default) for each (x, y) item, plus a flag when both inputs are zero (the
// angle is then 0). One item is taken per clock while o_stall is low; each
// result passes through 2 magnitude stages, 16 divider stages (one quotient
// bit each), 14 polynomial stages (square and six multiply/round pairs), 2
// quadrant restore stages and the output register. A single skid
// slot behind the output register takes one more result while the output is
// stalled; o_stall is registered and rises once that slot is full, freezing
// the whole pipeline until the output is taken.
module atan2_poly_approx_top #(
    parameter int COORD_WIDTH     = a2pa_pkg::DEF_COORD_WIDTH,
    parameter int ANGLE_FRAC_BITS = a2pa_pkg::DEF_ANGLE_FRAC_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [COORD_WIDTH-1:0]        i_coord_x,
    input  logic signed [COORD_WIDTH-1:0]        i_coord_y,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [a2pa_pkg::ANGLE_W-1:0]  o_angle,
    output logic                                 o_both_zero
);
    import a2pa_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int TW = ANGLE_FRAC_BITS + 4;
    localparam int SW = (TW > ANGLE_W) ? TW : ANGLE_W;

    localparam logic signed [TW-1:0] PI_T      = TW'(pi_fixed(ANGLE_FRAC_BITS));
    localparam logic signed [TW-1:0] HALF_PI_T = TW'(half_pi_fixed(ANGLE_FRAC_BITS));
    localparam logic signed [SW-1:0] SAT_HI    = SW'(32'sd32767);
    localparam logic signed [SW-1:0] SAT_LO    = SW'(-32'sd32768);

    logic en;
    logic r_skid_v;

    assign en      = ~r_skid_v;
    assign o_stall = r_skid_v;

    // stage 0: magnitudes and signs
    logic          r_s0_v;
    logic [CW-1:0] r_s0_ax, r_s0_ay;
    logic          r_s0_xn, r_s0_yn;

    // stage 1: order magnitudes
    logic          r_s1_v;
    logic [CW-1:0] r_s1_mx, r_s1_mn;
    t_side         r_s1_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
            r_s1_v <= 1'b0;
        end else if (en) begin
            r_s0_v <= i_valid;
            r_s1_v <= r_s0_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // the most negative value wraps to 2^(CW-1), exact as unsigned
            r_s0_ax <= i_coord_x[CW-1] ? CW'(-i_coord_x) : CW'(i_coord_x);
            r_s0_ay <= i_coord_y[CW-1] ? CW'(-i_coord_y) : CW'(i_coord_y);
            r_s0_xn <= i_coord_x[CW-1];
            r_s0_yn <= i_coord_y[CW-1];

            r_s1_side.swap  <= r_s0_ay > r_s0_ax;
            r_s1_side.zero  <= (r_s0_ax == '0) && (r_s0_ay == '0);
            r_s1_side.x_neg <= r_s0_xn;
            r_s1_side.y_neg <= r_s0_yn;
            r_s1_mx         <= (r_s0_ay > r_s0_ax) ? r_s0_ay : r_s0_ax;
            r_s1_mn         <= (r_s0_ay > r_s0_ax) ? r_s0_ax : r_s0_ay;
        end
    end

    logic               div_v;
    logic [RATIO_W-1:0] div_quo;
    t_side              div_side;

    a2pa_div #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s1_v),
        .i_num   (r_s1_mn),
        .i_den   (r_s1_mx),
        .i_side  (r_s1_side),
        .o_valid (div_v),
        .o_quo   (div_quo),
        .o_side  (div_side)
    );

    logic                 poly_v;
    logic signed [TW-1:0] poly_theta;
    t_side                poly_side;

    a2pa_poly #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_poly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (div_v),
        .i_ratio (div_quo),
        .i_side  (div_side),
        .o_valid (poly_v),
        .o_theta (poly_theta),
        .o_side  (poly_side)
    );

    // restore octant, then quadrant and sign in one subtract
    logic                 r_r0_v, r_r1_v;
    logic signed [TW-1:0] r_r0_t, r_r1_t;
    t_side                r_r0_side;
    logic                 r_r1_zero;
    logic signed [TW-1:0] q_base;
    logic signed [TW-1:0] q_res;

    always_comb begin
        q_base = r_r0_side.x_neg ? PI_T : '0;
        if (r_r0_side.x_neg ^ r_r0_side.y_neg) begin
            q_res = q_base - r_r0_t;
        end else begin
            q_res = r_r0_t - q_base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r0_v <= 1'b0;
            r_r1_v <= 1'b0;
        end else if (en) begin
            r_r0_v <= poly_v;
            r_r1_v <= r_r0_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_r0_t    <= poly_side.swap ? HALF_PI_T - poly_theta : poly_theta;
            r_r0_side <= poly_side;
            r_r1_t    <= q_res;
            r_r1_zero <= r_r0_side.zero;
        end
    end

    // saturate to the result word and force zero for the degenerate input
    logic signed [SW-1:0]      t_ext;
    logic signed [ANGLE_W-1:0] ld_angle;

    assign t_ext = SW'(r_r1_t);

    always_comb begin
        if (r_r1_zero) begin
            ld_angle = '0;
        end else if (t_ext > SAT_HI) begin
            ld_angle = ANGLE_W'(SAT_HI);
        end else if (t_ext < SAT_LO) begin
            ld_angle = ANGLE_W'(SAT_LO);
        end else begin
            ld_angle = t_ext[ANGLE_W-1:0];
        end
    end

    // output register with one skid slot
    logic                      r_out_v;
    logic signed [ANGLE_W-1:0] r_out_angle, r_skid_angle;
    logic                      r_out_zero, r_skid_zero;
    logic                      n_out_v, n_skid_v;
    logic signed [ANGLE_W-1:0] n_out_angle, n_skid_angle;
    logic                      n_out_zero, n_skid_zero;
    logic                      take;

    assign take = r_out_v & ~i_stall;

    always_comb begin
        n_out_v      = r_out_v;
        n_skid_v     = r_skid_v;
        n_out_angle  = r_out_angle;
        n_out_zero   = r_out_zero;
        n_skid_angle = r_skid_angle;
        n_skid_zero  = r_skid_zero;
        if (r_skid_v) begin
            if (take) begin
                n_out_angle = r_skid_angle;
                n_out_zero  = r_skid_zero;
                n_skid_v    = 1'b0;
            end
        end else if (r_r1_v) begin
            if (!r_out_v || take) begin
                n_out_v     = 1'b1;
                n_out_angle = ld_angle;
                n_out_zero  = r_r1_zero;
            end else begin
                n_skid_v     = 1'b1;
                n_skid_angle = ld_angle;
                n_skid_zero  = r_r1_zero;
            end
        end else if (take) begin
            n_out_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_out_v  <= n_out_v;
            r_skid_v <= n_skid_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_angle  <= n_out_angle;
        r_out_zero   <= n_out_zero;
        r_skid_angle <= n_skid_angle;
        r_skid_zero  <= n_skid_zero;
    end

    assign o_valid     = r_out_v;
    assign o_angle     = r_out_angle;
    assign o_both_zero = r_out_zero;

    // skid slot is only ever filled behind a held output
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid slot full with no output item");

    // a finished item meeting a stalled output must land in the skid slot
    a_skid_catch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_r1_v && r_out_v && i_stall && !r_skid_v) |=> r_skid_v)
        else $error("item dropped while output stalled");

    // taking the output drains the skid slot into the output register
    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && take) |=> (!r_skid_v && r_out_v))
        else $error("skid slot not drained after output taken");

    // degenerate input always gives a zero angle
    a_zero_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_both_zero) |-> (o_angle == '0))
        else $error("both-zero item with non-zero angle");

endmodule

// ===== rtl/a2pa_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, min/max ratio.
// Depends on a2pa_pkg (ratio width, side struct).
module a2pa_div #(
    parameter int COORD_WIDTH = a2pa_pkg::DEF_COORD_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  logic [COORD_WIDTH-1:0]         i_num,
    input  logic [COORD_WIDTH-1:0]         i_den,
    input  a2pa_pkg::t_side                i_side,
    output logic                           o_valid,
    output logic [a2pa_pkg::RATIO_W-1:0]   o_quo,
    output a2pa_pkg::t_side                o_side
);
    import a2pa_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int QB = RATIO_W;

    logic          r_v    [QB];
    logic [CW-1:0] r_rem  [QB];
    logic [CW-1:0] r_den  [QB];
    logic [QB-1:0] r_quo  [QB];
    t_side         r_side [QB];

    genvar g;
    generate
        for (g = 0; g < QB; g++) begin : g_stage
            logic [CW-1:0] rem_sh;
            logic [CW-1:0] den;
            logic [CW:0]   diff;
            logic [QB-1:0] quo_in;
            logic          v_in;
            t_side         side_in;
            logic          qbit;

            if (g == 0) begin : g_first
                assign rem_sh  = i_num;
                assign den     = i_den;
                assign quo_in  = '0;
                assign v_in    = i_valid;
                assign side_in = i_side;
            end else begin : g_next
                // remainder stays below the divisor, so its top bit is clear
                assign rem_sh  = {r_rem[g-1][CW-2:0], 1'b0};
                assign den     = r_den[g-1];
                assign quo_in  = r_quo[g-1];
                assign v_in    = r_v[g-1];
                assign side_in = r_side[g-1];
            end

            assign diff = {1'b0, rem_sh} - {1'b0, den};
            assign qbit = ~diff[CW];

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[g] <= 1'b0;
                end else if (i_en) begin
                    r_v[g] <= v_in;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[g]  <= qbit ? diff[CW-1:0] : rem_sh;
                    r_den[g]  <= den;
                    r_quo[g]  <= {quo_in[QB-2:0], qbit};
                    r_side[g] <= side_in;
                end
            end
        end
    endgenerate

    assign o_valid = r_v[QB-1];
    assign o_quo   = r_quo[QB-1];
    assign o_side  = r_side[QB-1];

endmodule

// ===== rtl/a2pa_poly.sv =====
// Horner evaluation of the octant arctangent: square, five multiply/round-add
// step pairs, final multiply by the ratio and rounding. Depends on a2pa_pkg.
module a2pa_poly #(
    parameter int ANGLE_FRAC_BITS = a2pa_pkg::DEF_ANGLE_FRAC_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  logic [a2pa_pkg::RATIO_W-1:0]   i_ratio,
    input  a2pa_pkg::t_side                i_side,
    output logic                           o_valid,
    output logic signed [ANGLE_FRAC_BITS+3:0] o_theta,
    output a2pa_pkg::t_side                o_side
);
    import a2pa_pkg::*;

    localparam int TW     = ANGLE_FRAC_BITS + 4;
    localparam int SQ_W   = 2 * RATIO_W;
    localparam int STEPS  = COEF_COUNT - 1;
    localparam int FIN_SH = 31 - ANGLE_FRAC_BITS;

    localparam logic [SQ_W-1:0]          SQ_HALF  = SQ_W'(1) << (RATIO_FRAC - 1);
    localparam logic signed [PROD_W-1:0] H_HALF   = PROD_W'(1) << (RATIO_FRAC - 1);
    localparam logic signed [PROD_W-1:0] FIN_HALF = PROD_W'(1) << (FIN_SH - 1);

    // square: multiply, then round
    logic               r_q0_v, r_q1_v;
    t_side              r_q0_side, r_q1_side;
    logic [RATIO_W-1:0] r_q0_r, r_q1_r, r_q1_s;
    logic [SQ_W-1:0]    r_q0_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q0_v <= 1'b0;
            r_q1_v <= 1'b0;
        end else if (i_en) begin
            r_q0_v <= i_valid;
            r_q1_v <= r_q0_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q0_side <= i_side;
            r_q0_r    <= i_ratio;
            r_q0_prod <= SQ_W'(i_ratio) * SQ_W'(i_ratio);
            r_q1_side <= r_q0_side;
            r_q1_r    <= r_q0_r;
            r_q1_s    <= RATIO_W'((r_q0_prod + SQ_HALF) >> RATIO_FRAC);
        end
    end

    // Horner steps
    logic                      r_hm_v    [STEPS];
    logic                      r_ha_v    [STEPS];
    t_side                     r_hm_side [STEPS];
    t_side                     r_ha_side [STEPS];
    logic [RATIO_W-1:0]        r_hm_r    [STEPS];
    logic [RATIO_W-1:0]        r_ha_r    [STEPS];
    logic [RATIO_W-1:0]        r_hm_s    [STEPS];
    logic [RATIO_W-1:0]        r_ha_s    [STEPS];
    logic signed [PROD_W-1:0]  r_hm_prod [STEPS];
    t_acc                      r_ha_acc  [STEPS];

    genvar k;
    generate
        for (k = 0; k < STEPS; k++) begin : g_step
            logic                     v_in;
            t_side                    side_in;
            logic [RATIO_W-1:0]       r_in;
            logic [RATIO_W-1:0]       s_in;
            t_acc                     acc_in;
            logic signed [PROD_W-1:0] rnd;

            if (k == 0) begin : g_first
                assign v_in    = r_q1_v;
                assign side_in = r_q1_side;
                assign r_in    = r_q1_r;
                assign s_in    = r_q1_s;
                assign acc_in  = COEF[0];
            end else begin : g_next
                assign v_in    = r_ha_v[k-1];
                assign side_in = r_ha_side[k-1];
                assign r_in    = r_ha_r[k-1];
                assign s_in    = r_ha_s[k-1];
                assign acc_in  = r_ha_acc[k-1];
            end

            // floor of (prod + half) / 2^15, i.e. round half up
            assign rnd = r_hm_prod[k] + H_HALF;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_hm_v[k] <= 1'b0;
                    r_ha_v[k] <= 1'b0;
                end else if (i_en) begin
                    r_hm_v[k] <= v_in;
                    r_ha_v[k] <= r_hm_v[k];
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_hm_side[k] <= side_in;
                    r_hm_r[k]    <= r_in;
                    r_hm_s[k]    <= s_in;
                    r_hm_prod[k] <= PROD_W'(acc_in) * PROD_W'($signed({1'b0, s_in}));
                    r_ha_side[k] <= r_hm_side[k];
                    r_ha_r[k]    <= r_hm_r[k];
                    r_ha_s[k]    <= r_hm_s[k];
                    r_ha_acc[k]  <= ACC_W'(rnd >>> RATIO_FRAC) + COEF[k+1];
                end
            end
        end
    endgenerate

    // final multiply by the ratio and rounding to the angle format
    logic                     r_fm_v, r_fr_v;
    t_side                    r_fm_side, r_fr_side;
    logic signed [PROD_W-1:0] r_fm_prod;
    logic signed [TW-1:0]     r_fr_t;
    logic signed [PROD_W-1:0] fin_rnd;

    assign fin_rnd = r_fm_prod + FIN_HALF;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fm_v <= 1'b0;
            r_fr_v <= 1'b0;
        end else if (i_en) begin
            r_fm_v <= r_ha_v[STEPS-1];
            r_fr_v <= r_fm_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fm_side <= r_ha_side[STEPS-1];
            r_fm_prod <= PROD_W'(r_ha_acc[STEPS-1])
                         * PROD_W'($signed({1'b0, r_ha_r[STEPS-1]}));
            r_fr_side <= r_fm_side;
            r_fr_t    <= TW'(fin_rnd >>> FIN_SH);
        end
    end

    assign o_valid = r_fr_v;
    assign o_theta = r_fr_t;
    assign o_side  = r_fr_side;

endmodule

// ===== bench/atan2_poly_approx_checker.sv =====
// Watches both channels of atan2_poly_approx_top, predicts each angle and compares.
// Depends on a2pa_pkg for widths and the pi constant.
module atan2_poly_approx_checker #(
    parameter int COORD_WIDTH     = a2pa_pkg::DEF_COORD_WIDTH,
    parameter int ANGLE_FRAC_BITS = a2pa_pkg::DEF_ANGLE_FRAC_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    input  logic                                 i_in_stall,
    input  logic signed [COORD_WIDTH-1:0]        i_coord_x,
    input  logic signed [COORD_WIDTH-1:0]        i_coord_y,
    input  logic                                 i_out_valid,
    input  logic                                 i_out_stall,
    input  logic signed [a2pa_pkg::ANGLE_W-1:0]  i_angle,
    input  logic                                 i_both_zero,
    output int                                   o_mismatches,
    output int                                   o_outstanding
);

    // octant polynomial, 16 fraction bits, highest power first
    localparam longint ATAN_COEF [6] = '{-883, 3767, -7946, 12821, -21823, 65536};

    localparam longint PI_Q = longint'((a2pa_pkg::PI_Q60
        + (64'd1 << (59 - ANGLE_FRAC_BITS))) >> (60 - ANGLE_FRAC_BITS));
    localparam longint HALF_PI_Q = longint'((a2pa_pkg::PI_Q60
        + (64'd1 << (60 - ANGLE_FRAC_BITS))) >> (61 - ANGLE_FRAC_BITS));

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0]       x;
        logic signed [COORD_WIDTH-1:0]       y;
        logic signed [a2pa_pkg::ANGLE_W-1:0] angle;
        logic                                both_zero;
    } t_angle_result;

    t_angle_result angle_q [$];

    function automatic t_angle_result predict_angle(input logic signed [COORD_WIDTH-1:0] x,
                                                    input logic signed [COORD_WIDTH-1:0] y);
        longint        sx, sy, ax, ay, mag_hi, mag_lo, ratio, square, acc, theta;
        t_angle_result res;
        sx = x;
        sy = y;
        ax = (sx < 0) ? -sx : sx;
        ay = (sy < 0) ? -sy : sy;
        mag_hi = (ax > ay) ? ax : ay;
        mag_lo = (ax > ay) ? ay : ax;
        res.x = x;
        res.y = y;
        res.angle = '0;
        res.both_zero = 1'b1;
        if (mag_hi == 0)
            return res;
        res.both_zero = 1'b0;
        ratio  = (mag_lo << 15) / mag_hi;
        square = (ratio * ratio + (longint'(1) << 14)) >>> 15;
        acc = ATAN_COEF[0];
        for (int i = 1; i < 6; i++)
            acc = ((acc * square + (longint'(1) << 14)) >>> 15) + ATAN_COEF[i];
        // arithmetic shift floors, so adding half first rounds half up
        theta = (acc * ratio + (longint'(1) << (30 - ANGLE_FRAC_BITS)))
                >>> (31 - ANGLE_FRAC_BITS);
        if (ay > ax)
            theta = HALF_PI_Q - theta;
        if (sx < 0)
            theta = PI_Q - theta;
        if (sy < 0)
            theta = -theta;
        if (theta > 32767)
            theta = 32767;
        if (theta < -32768)
            theta = -32768;
        res.angle = theta[a2pa_pkg::ANGLE_W-1:0];
        return res;
    endfunction

    initial begin
        o_mismatches  = 0;
        o_outstanding = 0;
    end

    always @(posedge i_clk) begin
        t_angle_result exp_res;
        if (i_rst_n) begin
            if (i_out_valid && !i_out_stall) begin
                if (angle_q.size() == 0) begin
                    o_mismatches <= o_mismatches + 1;
                    $display("%0t: unexpected item: expected none, got angle %0d both_zero %0b",
                             $time, i_angle, i_both_zero);
                end else begin
                    exp_res = angle_q.pop_front();
                    if (i_angle !== exp_res.angle || i_both_zero !== exp_res.both_zero) begin
                        o_mismatches <= o_mismatches + 1;
                        if (i_angle !== exp_res.angle)
                            $display("%0t: angle for x=%0d y=%0d: expected %0d, got %0d",
                                     $time, exp_res.x, exp_res.y, exp_res.angle, i_angle);
                        if (i_both_zero !== exp_res.both_zero)
                            $display("%0t: both_zero for x=%0d y=%0d: expected %0b, got %0b",
                                     $time, exp_res.x, exp_res.y, exp_res.both_zero,
                                     i_both_zero);
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                angle_q.push_back(predict_angle(i_coord_x, i_coord_y));
            o_outstanding <= angle_q.size();
        end
    end

endmodule

// ===== bench/atan2_poly_approx_top_tb.sv =====
// Stimulus and verdict for atan2_poly_approx_top: directed corners, then random items.
// Depends on a2pa_pkg, the block itself and atan2_poly_approx_checker.
module atan2_poly_approx_top_tb;

    localparam int RANDOM_ITEMS = 1150;
    localparam int MAX_IDLE     = 18;
    localparam int SETTLE       = 60;

    // corners: axes, extremes, equal magnitudes, x negative on the axis
    localparam int N_CORNERS = 24;
    localparam shortint CORNER_X [N_CORNERS] = '{
        0, 32767, -32768, 0, 0, -32768, 32767, -1, -5, 1, -1, 100,
        3, -7, -32768, 32767, 1, -32768, 1, 0, 0, -1, 12345, -32767
    };
    localparam shortint CORNER_Y [N_CORNERS] = '{
        0, 0, 0, 32767, -32768, -32768, 32767, 0, 0, 1, -1, -100,
        7, 3, 32767, -32768, -32768, 1, 0, 1, -1, 1, -23456, 32767
    };

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic signed [15:0] i_coord_x;
    logic signed [15:0] i_coord_y;
    logic               o_valid;
    logic               i_stall;
    logic signed [15:0] o_angle;
    logic               o_both_zero;
    int                 mismatches;
    int                 outstanding;

    atan2_poly_approx_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_coord_x   (i_coord_x),
        .i_coord_y   (i_coord_y),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_angle     (o_angle),
        .o_both_zero (o_both_zero)
    );

    atan2_poly_approx_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_coord_x     (i_coord_x),
        .i_coord_y     (i_coord_y),
        .i_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .i_angle       (o_angle),
        .i_both_zero   (o_both_zero),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_coords(input logic signed [15:0] x, input logic signed [15:0] y,
                               input int gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_coord_x <= x;
        i_coord_y <= y;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    // hold off until every expected angle has come out
    task automatic drain_results();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (outstanding != 0);
    endtask

    task automatic pick_coords(output logic signed [15:0] x, output logic signed [15:0] y);
        shortint corner [6];
        int      kind;
        int      mag;
        corner = '{-32768, -32767, -1, 0, 1, 32767};
        kind = $urandom_range(0, 99);
        if (kind < 8) begin
            x = '0;
            y = '0;
        end else if (kind < 18) begin
            x = 16'($urandom);
            y = '0;
            if ($urandom_range(0, 1))
                {x, y} = {y, x};
        end else if (kind < 30) begin
            mag = $urandom_range(1, 32767);
            x = 16'($urandom_range(0, 1) ? -mag : mag);
            y = 16'($urandom_range(0, 1) ? -mag : mag);
        end else if (kind < 40) begin
            x = corner[$urandom_range(0, 5)];
            y = corner[$urandom_range(0, 5)];
        end else if (kind < 50) begin
            x = 16'($urandom_range(0, 31) - 16);
            y = 16'($urandom_range(0, 31) - 16);
        end else begin
            x = 16'($urandom);
            y = 16'($urandom);
        end
    endtask

    // sink: stall for a drawn number of cycles ahead of each item taken, none in a burst
    initial begin : sink
        int burst;
        int taken;
        int hold;
        i_stall = 1'b0;
        burst   = 0;
        taken   = 0;
        forever begin
            @(negedge i_clk);
            if (taken % 64 == 0)
                burst = ($urandom_range(0, 3) == 0);
            hold = burst ? 0 : $urandom_range(0, MAX_IDLE);
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(negedge i_clk);
                i_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!(o_valid && !i_stall));
            taken++;
        end
    end

    initial begin : stimulus
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        int                 burst;
        i_rst_n   = 1'b0;
        i_valid   = 1'b0;
        i_coord_x = '0;
        i_coord_y = '0;
        burst     = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < N_CORNERS; i++)
            send_coords(CORNER_X[i], CORNER_Y[i], $urandom_range(0, MAX_IDLE));
        drain_results();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 50 == 0)
                burst = ($urandom_range(0, 3) == 0);
            if (n == RANDOM_ITEMS / 2)
                drain_results();
            pick_coords(cx, cy);
            send_coords(cx, cy, burst ? 0 : $urandom_range(0, MAX_IDLE));
        end

        drain_results();
        repeat (SETTLE) @(negedge i_clk);
        if (mismatches == 0 && outstanding == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin : watchdog
        #5000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
